FILE: design/sms_pkg.sv
`default_nettype none
package sms_pkg;

  localparam int SCORE_W      = 32;
  localparam int TAG_W        = 20;
  localparam int COUNT_W      = 9;
  localparam int CAPACITY_DEF = 256;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_PUSH_OK   = 2'd0,
    ST_PUSH_FULL = 2'd1,
    ST_POP_OK    = 2'd2,
    ST_POP_EMPTY = 2'd3
  } sms_status_t;

  // per-beat shift command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } sms_ctl_t;

endpackage
`default_nettype wire

FILE: design/sms_cell.sv
`default_nettype none
module sms_cell
  import sms_pkg::*;
(
  input  wire                       clk,
  input  sms_ctl_t                  ctl,
  input  wire                       occupied,
  input  wire                       left_keep,
  input  wire logic signed [SCORE_W-1:0] new_score,
  input  wire logic [TAG_W-1:0]     new_tag,
  input  wire logic signed [SCORE_W-1:0] left_score,
  input  wire logic [TAG_W-1:0]     left_tag,
  input  wire logic signed [SCORE_W-1:0] right_score,
  input  wire logic [TAG_W-1:0]     right_tag,
  output logic                      keep,
  output logic signed [SCORE_W-1:0] score,
  output logic [TAG_W-1:0]          tag
);

  logic signed [SCORE_W-1:0] score_r, score_nxt;
  logic [TAG_W-1:0]          tag_r, tag_nxt;

  // ties stay ahead of the new record
  assign keep  = occupied && (score_r >= new_score);
  assign score = score_r;
  assign tag   = tag_r;

  always_comb begin
    score_nxt = score_r;
    tag_nxt   = tag_r;
    priority if (ctl.push) begin
      if (!left_keep) begin
        score_nxt = left_score;
        tag_nxt   = left_tag;
      end else if (!keep) begin
        score_nxt = new_score;
        tag_nxt   = new_tag;
      end
    end else if (ctl.pop) begin
      score_nxt = right_score;
      tag_nxt   = right_tag;
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
    tag_r   <= tag_nxt;
  end

endmodule
`default_nettype wire

FILE: design/sort_moves_by_score_descending.sv
// The result of an accepted beat is registered and presented right after the edge
//   that accepts it.
// Throughput: one beat per cycle; every cell compares and shifts in the same cycle,
//   and a new beat enters when the output register is empty or drains in that cycle.
// Reset (rst_n low, synchronous): record count and output valid clear.
// Cell contents are not cleared; only cells below the count are ever read.
`default_nettype none
module sort_moves_by_score_descending
  import sms_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire                       in_op,
  input  wire logic signed [SCORE_W-1:0] in_move_score,
  input  wire logic [TAG_W-1:0]     in_move_tag,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic signed [SCORE_W-1:0] out_score,
  output logic [TAG_W-1:0]          out_tag,
  output logic [1:0]                out_status,
  output logic [COUNT_W-1:0]        out_stored_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // ---------------------------------------------------------------------------
  // Handshake: the output register holds one result; a new beat enters when
  // that register is empty or drains in the same cycle.
  // ---------------------------------------------------------------------------
  logic in_fire;
  logic out_valid_r, out_valid_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Occupancy
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             is_full, is_empty;

  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);

  sms_ctl_t ctl;
  assign ctl.push = in_fire && (in_op == OP_PUSH) && !is_full;
  assign ctl.pop  = in_fire && (in_op == OP_POP) && !is_empty;

  always_comb begin
    count_nxt = count_r;
    if (ctl.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Cell row, cell 0 holds the highest score. On a push every cell that keeps
  // its record (occupied, score >= new) stays; the first one that does not
  // takes the new record, the rest take their left neighbor. On a pop every
  // cell takes its right neighbor.
  // ---------------------------------------------------------------------------
  logic signed [SCORE_W-1:0] cell_score [CAPACITY];
  logic [TAG_W-1:0]          cell_tag   [CAPACITY];
  logic [CAPACITY-1:0]       cell_keep;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      occ;
    logic                      lkeep;
    logic signed [SCORE_W-1:0] lscore, rscore;
    logic [TAG_W-1:0]          ltag, rtag;

    assign occ = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign lkeep  = 1'b1;
      assign lscore = in_move_score;
      assign ltag   = in_move_tag;
    end else begin : g_mid
      assign lkeep  = cell_keep[i-1];
      assign lscore = cell_score[i-1];
      assign ltag   = cell_tag[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      // past the end: content is dead once the count drops
      assign rscore = '0;
      assign rtag   = '0;
    end else begin : g_inner
      assign rscore = cell_score[i+1];
      assign rtag   = cell_tag[i+1];
    end

    sms_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (occ),
      .left_keep  (lkeep),
      .new_score  (in_move_score),
      .new_tag    (in_move_tag),
      .left_score (lscore),
      .left_tag   (ltag),
      .right_score(rscore),
      .right_tag  (rtag),
      .keep       (cell_keep[i]),
      .score      (cell_score[i]),
      .tag        (cell_tag[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic signed [SCORE_W-1:0] res_score_r, res_score_nxt;
  logic [TAG_W-1:0]          res_tag_r, res_tag_nxt;
  sms_status_t               res_status_r, res_status_nxt;
  logic [COUNT_W-1:0]        res_count_r, res_count_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    res_score_nxt  = res_score_r;
    res_tag_nxt    = res_tag_r;
    res_status_nxt = res_status_r;
    res_count_nxt  = res_count_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      res_score_nxt = '0;
      res_tag_nxt   = '0;
      res_count_nxt = COUNT_W'(count_nxt);
      unique case (in_op)
        OP_PUSH: begin
          res_status_nxt = is_full ? ST_PUSH_FULL : ST_PUSH_OK;
        end
        OP_POP: begin
          if (is_empty) begin
            res_status_nxt = ST_POP_EMPTY;
          end else begin
            res_status_nxt = ST_POP_OK;
            res_score_nxt  = cell_score[0];
            res_tag_nxt    = cell_tag[0];
          end
        end
        default: begin
          res_status_nxt = ST_POP_EMPTY;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_score_r  <= res_score_nxt;
    res_tag_r    <= res_tag_nxt;
    res_status_r <= res_status_nxt;
    res_count_r  <= res_count_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_score        = res_score_r;
  assign out_tag          = res_tag_r;
  assign out_status       = res_status_r;
  assign out_stored_count = res_count_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("record count above capacity");

  a_pop_front: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |=> (out_score == $past(cell_score[0])) && (out_tag == $past(cell_tag[0])))
    else $error("popped record is not the front cell");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("push did not grow the count");

  a_front_order: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r > CNT_W'(1)) |-> (cell_score[0] >= cell_score[1]))
    else $error("front cells out of order");

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import sms_pkg::*;

  // One stored record: signed ordering key plus the opaque move tag.
  typedef struct {
    logic signed [SCORE_W-1:0] score;
    logic [TAG_W-1:0]          tag;
  } move_rec_t;

  // What the block should return for one beat.
  typedef struct {
    logic signed [SCORE_W-1:0] score;
    logic [TAG_W-1:0]          tag;
    sms_status_t               status;
    logic [COUNT_W-1:0]        count;
  } rank_result_t;

  // Keeps its own ranked copy of the store and the results still owed.
  class move_rank_board;
    move_rec_t    ranked[$];    // front = highest score, ties in push order
    rank_result_t owed[$];
    int           errors = 0;
    int           mismatches = 0;

    function int pending();
      return owed.size();
    endfunction

    // Applies one accepted input beat to the ranked copy and queues its result.
    function void note_beat(logic op, logic signed [SCORE_W-1:0] score,
                            logic [TAG_W-1:0] tag);
      rank_result_t res;
      move_rec_t    rec;
      int           pos;
      res.score = '0;
      res.tag   = '0;
      if (op == OP_PUSH) begin
        if (ranked.size() >= CAPACITY_DEF) begin
          res.status = ST_PUSH_FULL;
        end else begin
          // new record goes behind every record with an equal or higher score
          pos = 0;
          while (pos < ranked.size() && ranked[pos].score >= score) pos++;
          rec.score = score;
          rec.tag   = tag;
          ranked.insert(pos, rec);
          res.status = ST_PUSH_OK;
        end
      end else begin
        if (ranked.size() == 0) begin
          res.status = ST_POP_EMPTY;
        end else begin
          rec = ranked.pop_front();
          res.score  = rec.score;
          res.tag    = rec.tag;
          res.status = ST_POP_OK;
        end
      end
      res.count = COUNT_W'(ranked.size());
      owed.push_back(res);
    endfunction

    function void check_result(logic signed [SCORE_W-1:0] score, logic [TAG_W-1:0] tag,
                               logic [1:0] status, logic [COUNT_W-1:0] count);
      rank_result_t exp;
      if (owed.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing owed: score %0d tag %h status %0d count %0d",
                   $realtime, score, tag, status, count);
        return;
      end
      exp = owed.pop_front();
      if (score !== exp.score || tag !== exp.tag || status !== exp.status ||
          count !== exp.count) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp score %0d tag %h status %0d count %0d, got score %0d tag %h status %0d count %0d",
                   $realtime, exp.score, exp.tag, exp.status, exp.count,
                   score, tag, status, count);
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_op = OP_PUSH;
  logic signed [SCORE_W-1:0] in_move_score = '0;
  logic [TAG_W-1:0]          in_move_tag = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [SCORE_W-1:0] out_score;
  logic [TAG_W-1:0]          out_tag;
  logic [1:0]                out_status;
  logic [COUNT_W-1:0]        out_stored_count;

  move_rank_board board;
  int             random_beats = 0;

  sort_moves_by_score_descending DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_move_score    (in_move_score),
    .in_move_tag      (in_move_tag),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_score        (out_score),
    .out_tag          (out_tag),
    .out_status       (out_status),
    .out_stored_count (out_stored_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver back-pressure: a mode is held for a random stretch of cycles.
  // Mode 0 never stalls, 1 stalls lightly, 2 stalls heavily, 3 holds off in
  // solid runs of random length so results wait in the output register.
  int rx_mode = 0;
  int rx_left = 0;
  int rx_hold = 0;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(3);
      rx_left = $urandom_range(32, 256);
    end else begin
      rx_left = rx_left - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(99) < 80);
      2: out_ready <= ($urandom_range(99) < 25);
      default: begin
        if (rx_hold == 0) begin
          rx_hold = $urandom_range(1, 12);
          out_ready <= ~out_ready;
        end else begin
          rx_hold = rx_hold - 1;
        end
      end
    endcase
  end

  // Result monitor: every beat taken on the output side is checked in order.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result(out_score, out_tag, out_status, out_stored_count);
  end

  // Holds one beat on the input until the block takes it. Valid is left high
  // so the next beat can follow back to back.
  task automatic send_beat(logic op, logic signed [SCORE_W-1:0] score,
                           logic [TAG_W-1:0] tag);
    in_valid      <= 1'b1;
    in_op         <= op;
    in_move_score <= score;
    in_move_tag   <= tag;
    do @(posedge clk); while (!in_ready);
    board.note_beat(op, score, tag);
  endtask

  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Sender holds off until every owed result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Score flavors: 0 full range, 1 narrow band around zero (lots of ties),
  // 2 the signed extremes, zero and their neighbors, 3 a blend of the others.
  function automatic logic signed [SCORE_W-1:0] pick_score(int flavor);
    int band;
    case (flavor)
      0: return $urandom;
      1: begin
        band = int'($urandom_range(8)) - 4;
        return band;
      end
      2: begin
        case ($urandom_range(5))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0000_0000;
          3: return -32'sd1;
          4: return 32'sh7FFF_FFFE;
          default: return 32'sh8000_0001;
        endcase
      end
      default: return pick_score($urandom_range(2));
    endcase
  endfunction

  // A run of random beats, sent in bursts with random gaps. Pops carry random
  // score and tag too, since the block must ignore them.
  task automatic run_phase(int beats, int push_pct, int flavor, int max_burst);
    int burst_left;
    int k;
    logic op;
    burst_left = $urandom_range(1, max_burst);
    for (k = 0; k < beats; k++) begin
      op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
      send_beat(op, pick_score(flavor), TAG_W'($urandom));
      random_beats++;
      burst_left--;
      if (burst_left == 0) begin
        pause_sender(($urandom_range(3) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 4));
        burst_left = $urandom_range(1, max_burst);
      end
    end
  endtask

  initial begin
    int push_pct;
    board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: pop on empty, extremes of score and tag, ties, ignored fields.
    send_beat(OP_POP, 32'sh1234_5678, 20'hABCDE);
    send_beat(OP_PUSH, 32'sh0000_0000, 20'h00000);
    send_beat(OP_PUSH, 32'sh7FFF_FFFF, 20'hFFFFF);
    send_beat(OP_PUSH, 32'sh8000_0000, 20'h00000);
    pause_sender(3);
    send_beat(OP_PUSH, -32'sd1, 20'h5A5A5);
    send_beat(OP_PUSH, 32'sh0000_0000, 20'h00001);
    send_beat(OP_PUSH, 32'sh0000_0000, 20'h00002);
    send_beat(OP_PUSH, 32'sh7FFF_FFFF, 20'hA5A5A);
    send_beat(OP_PUSH, 32'sh8000_0000, 20'hFFFFF);
    // pops come out highest first, equal scores in push order
    repeat (8) send_beat(OP_POP, 32'sh7FFF_FFFF, 20'hFFFFF);
    send_beat(OP_POP, 32'sh8000_0000, 20'h00000);
    send_beat(OP_POP, -32'sd1, 20'hFFFFF);
    drain_results();

    // Fill past capacity so pushes get dropped, then drain past empty.
    run_phase(270, 100, 3, 24);
    drain_results();
    run_phase(280, 0, 0, 40);
    drain_results();

    // Mixed phases with a random push/pop balance and score flavor. Some
    // phases run without gaps, and now and then the sender waits for the
    // block to catch up completely.
    while (random_beats < 1150) begin
      case ($urandom_range(3))
        0: push_pct = 10;
        1: push_pct = 50;
        2: push_pct = 60;
        default: push_pct = 90;
      endcase
      run_phase($urandom_range(40, 120), push_pct, $urandom_range(3),
                ($urandom_range(3) == 0) ? 200 : 24);
      if ($urandom_range(2) == 0)
        drain_results();
    end

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("sort_moves_by_score_descending verification clean");
    end else begin
      $display("sort_moves_by_score_descending verification failed");
    end
    $finish;
  end

  // Watchdog: far above the slowest legal run of this stimulus.
  initial begin
    #2_000_000;
    $display("sort_moves_by_score_descending verification failed");
    $finish;
  end

endmodule
